// ----- hdl/skp_pkg.sv -----
`timescale 1ns / 1ps

package skp_pkg;

    // fixed field widths of the channel payloads
    localparam int COORD_BITS = 16;
    localparam int OUT_IDX_W  = 6;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int DIMS_W     = 3;

    // register index, taken from paddr[2]
    localparam logic REG_DIMS_IN_USE = 1'b0;
    localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd4;

    // one point as it arrives
    typedef struct packed {
        logic [COORD_BITS-1:0] coord_a;
        logic [COORD_BITS-1:0] coord_b;
        logic [COORD_BITS-1:0] coord_c;
        logic [COORD_BITS-1:0] coord_d;
        logic                  last_point;
    } t_in_item;

    // one skyline index as it leaves
    typedef struct packed {
        logic [OUT_IDX_W-1:0] point_index;
        logic                 last_result;
        logic                 overflow;
    } t_out_item;

    // controller states
    typedef enum logic [5:0] {
        ST_LOAD = 6'b000001,
        ST_INIT = 6'b000010,
        ST_MAX  = 6'b000100,
        ST_PICK = 6'b001000,
        ST_DOM  = 6'b010000,
        ST_EMIT = 6'b100000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic init;
        logic scan_start;
        logic do_max;
        logic do_dom;
        logic pick;
        logic emit_start;
        logic emit;
        logic clear;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_last;
        logic scan_done;
        logic alive_left;
        logic emit_done;
    } t_sts;

endpackage

// ----- hdl/skp_ram.sv -----
`timescale 1ns / 1ps

module skp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/skp_ctrl.sv -----
`timescale 1ns / 1ps

module skp_ctrl
    import skp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    // sequencing of load, max search, dominance sweep and emission
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            ST_LOAD: begin
                cmd.load = 1'b1;
                if (i_sts.in_last) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                cmd.init       = 1'b1;
                cmd.scan_start = 1'b1;
                n_state        = ST_MAX;
            end
            ST_MAX: begin
                cmd.do_max = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                cmd.pick       = 1'b1;
                cmd.scan_start = 1'b1;
                n_state        = ST_DOM;
            end
            ST_DOM: begin
                cmd.do_dom = 1'b1;
                if (i_sts.scan_done) begin
                    if (i_sts.alive_left) begin
                        cmd.scan_start = 1'b1;
                        n_state        = ST_MAX;
                    end else begin
                        cmd.emit_start = 1'b1;
                        n_state        = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                cmd.emit = 1'b1;
                if (i_sts.emit_done) begin
                    cmd.clear = 1'b1;
                    n_state   = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = cmd;

endmodule

// ----- hdl/skp_dp.sv -----
`timescale 1ns / 1ps

module skp_dp
    import skp_pkg::*;
#(
    parameter int MAX_POINTS  = 64,
    parameter int DIMS        = 4,
    parameter int COORD_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [DIMS_W-1:0] i_dims,
    input  logic              i_in_valid,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SW    = DIMS * COORD_WIDTH;
    localparam logic [MAX_POINTS-1:0] ONE_HOT0 = MAX_POINTS'(1);

    // control state
    logic [CNT_W-1:0]      r_count,     n_count;
    logic                  r_dropped,   n_dropped;
    logic [MAX_POINTS-1:0] r_alive,     n_alive;
    logic [MAX_POINTS-1:0] r_sky,       n_sky;
    logic                  r_have_best, n_have_best;
    logic                  r_issuing,   n_issuing;
    logic                  r_rd_vld,    n_rd_vld;
    logic                  r_out_valid, n_out_valid;

    // payload state
    logic [IDX_W-1:0]      r_addr,      n_addr;
    logic [IDX_W-1:0]      r_rd_idx,    n_rd_idx;
    logic                  r_rd_last,   n_rd_last;
    logic [SW-1:0]         r_best,      n_best;
    logic [IDX_W-1:0]      r_best_idx,  n_best_idx;
    logic [IDX_W-1:0]      r_ptr,       n_ptr;
    t_out_item             r_out_data,  n_out_data;

    logic                  in_fire;
    logic                  store_we;
    logic [SW-1:0]         wdata;
    logic [SW-1:0]         rdata;
    logic [3:0][COORD_BITS-1:0] in_coords;
    logic [DIMS-1:0]       use_dim;
    logic                  lex_gt;
    logic                  dominated;
    logic [IDX_W-1:0]      last_idx;
    logic                  rd_alive;
    logic                  out_free;
    logic                  cur_bit;
    logic [MAX_POINTS-1:0] sky_rest;
    logic                  emit_load;

    // input transaction and point packing
    assign in_fire   = i_in_valid && i_cmd.load;
    assign store_we  = in_fire && (r_count < CNT_W'(MAX_POINTS));
    assign in_coords = {i_in_data.coord_d, i_in_data.coord_c,
                        i_in_data.coord_b, i_in_data.coord_a};

    always_comb begin
        for (int k = 0; k < DIMS; k++) begin
            wdata[k*COORD_WIDTH +: COORD_WIDTH] = in_coords[k][COORD_WIDTH-1:0];
        end
    end

    skp_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (wdata),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    // dimensions taking part, zero counts as one
    always_comb begin
        for (int k = 0; k < DIMS; k++) begin
            use_dim[k] = (k == 0) || (DIMS_W'(k) < i_dims);
        end
    end

    // lexicographic and dominance compare of the read point against the best
    always_comb begin
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
        logic                   le_all;
        logic                   lt_any;
        lex_gt = 1'b0;
        le_all = 1'b1;
        lt_any = 1'b0;
        for (int k = DIMS - 1; k >= 0; k--) begin
            x = rdata[k*COORD_WIDTH +: COORD_WIDTH];
            y = r_best[k*COORD_WIDTH +: COORD_WIDTH];
            if (use_dim[k]) begin
                if (x != y) begin
                    lex_gt = (x > y);
                end
                if (x > y) begin
                    le_all = 1'b0;
                end
                if (x < y) begin
                    lt_any = 1'b1;
                end
            end
        end
        dominated = le_all && lt_any;
    end

    assign last_idx = IDX_W'(r_count - CNT_W'(1));
    assign rd_alive = r_rd_vld && r_alive[r_rd_idx];

    // emission walk over the skyline mask
    assign out_free  = !r_out_valid || !i_out_stall;
    assign cur_bit   = r_sky[r_ptr];
    assign sky_rest  = r_sky & ~(ONE_HOT0 << r_ptr);
    assign emit_load = i_cmd.emit && cur_bit && out_free;

    always_comb begin
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_alive     = r_alive;
        n_sky       = r_sky;
        n_have_best = r_have_best;
        n_issuing   = r_issuing;
        n_addr      = r_addr;
        n_rd_vld    = r_issuing;
        n_rd_idx    = r_addr;
        n_rd_last   = (r_addr == last_idx);
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_ptr       = r_ptr;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        // loading
        if (in_fire) begin
            if (store_we) begin
                n_count = r_count + CNT_W'(1);
            end else begin
                n_dropped = 1'b1;
            end
        end

        // every stored point starts alive
        if (i_cmd.init) begin
            for (int i = 0; i < MAX_POINTS; i++) begin
                n_alive[i] = (CNT_W'(i) < r_count);
            end
        end

        // read sweep over the stored points
        if (i_cmd.scan_start) begin
            n_addr    = '0;
            n_issuing = 1'b1;
        end else if (r_issuing) begin
            n_addr = r_addr + IDX_W'(1);
            if (r_addr == last_idx) begin
                n_issuing = 1'b0;
            end
        end

        // max search, the lowest index wins ties
        if (i_cmd.do_max && rd_alive && (!r_have_best || lex_gt)) begin
            n_best      = rdata;
            n_best_idx  = r_rd_idx;
            n_have_best = 1'b1;
        end

        // move the max to the skyline
        if (i_cmd.pick) begin
            n_alive[r_best_idx] = 1'b0;
            n_sky[r_best_idx]   = 1'b1;
            n_have_best         = 1'b0;
        end

        // drop points dominated by the max
        if (i_cmd.do_dom && rd_alive && dominated) begin
            n_alive[r_rd_idx] = 1'b0;
        end

        // output register drains
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.emit_start) begin
            n_ptr = '0;
        end else if (i_cmd.emit && (!cur_bit || out_free)) begin
            n_ptr = r_ptr + IDX_W'(1);
        end

        if (emit_load) begin
            n_sky[r_ptr]           = 1'b0;
            n_out_valid            = 1'b1;
            n_out_data.point_index = OUT_IDX_W'(r_ptr);
            n_out_data.last_result = (sky_rest == '0);
            n_out_data.overflow    = r_dropped;
        end

        // set finished
        if (i_cmd.clear) begin
            n_count   = '0;
            n_dropped = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_alive     <= '0;
            r_sky       <= '0;
            r_have_best <= 1'b0;
            r_issuing   <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_alive     <= n_alive;
            r_sky       <= n_sky;
            r_have_best <= n_have_best;
            r_issuing   <= n_issuing;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_rd_idx   <= n_rd_idx;
        r_rd_last  <= n_rd_last;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_ptr      <= n_ptr;
        r_out_data <= n_out_data;
    end

    assign o_sts.in_last    = in_fire && i_in_data.last_point;
    assign o_sts.scan_done  = r_rd_vld && r_rd_last;
    assign o_sts.alive_left = (n_alive != '0);
    assign o_sts.emit_done  = emit_load && (sky_rest == '0);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- hdl/skyline_pareto_maxima.sv -----
`timescale 1ns / 1ps

// Skyline (Pareto maxima) of a set of up to MAX_POINTS points. Points are
// loaded one per cycle; the point flagged last_point closes the set and
// starts the skyline pass, during which the input is stalled. Points past
// capacity are dropped and reported through the overflow flag of every
// result of the set. The pass repeats, per skyline point found, one
// lexicographic max sweep and one dominance sweep over the N stored points,
// both through the single read port of the point store, then walks the
// store positions (at most MAX_POINTS) to emit the indices in ascending
// order, held while the output is stalled. Only the first dims_in_use
// coordinates are compared (0 acts as 1, values above DIMS as DIMS).
// Loading of the next set may start while the final result still waits
// in the output register.
module skyline_pareto_maxima
    import skp_pkg::*;
#(
    parameter int MAX_POINTS  = 64,
    parameter int DIMS        = 4,
    parameter int COORD_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cmd              cmd;
    t_sts              sts;
    logic [DIMS_W-1:0] r_dims;
    logic              cfg_wr;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DIMS_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= DIMS_RESET;
        end else if (cfg_wr) begin
            r_dims <= pwdata[DIMS_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_DIMS_IN_USE) ? APB_DATA_W'(r_dims) : '0;

    // points are taken only while loading
    assign o_in_stall = !cmd.load;

    skp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    skp_dp #(
        .MAX_POINTS  (MAX_POINTS),
        .DIMS        (DIMS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_dims      (r_dims),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- test/tb_skyline_pareto_maxima.sv -----
`timescale 1ns / 1ps

module tb_skyline_pareto_maxima;
    import skp_pkg::*;

    localparam int MAX_PTS       = 64;
    localparam int AXES          = 4;
    localparam int N_ITEMS       = 380;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 400;
    // dims_in_use per random phase, lowest field first
    localparam logic [3*7-1:0] DIMS_SWEEP = {3'd4, 3'd5, 3'd3, 3'd2, 3'd0, 3'd7, 3'd1};

    // coordinate patterns for generated point sets
    typedef enum int {
        SET_SPREAD,
        SET_TIES,
        SET_TRADEOFF,
        SET_EXTREME
    } t_set_kind;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // skyline predictor state
    logic [COORD_BITS-1:0] pt_coord [MAX_PTS][AXES];
    int unsigned           pt_count   = 0;
    logic                  pt_dropped = 1'b0;
    logic [DIMS_W-1:0]     dims_cfg   = DIMS_RESET;

    t_in_item    pending_points[$];
    t_out_item   sky_expect[$];
    int unsigned queued         = 0;
    int unsigned mismatches     = 0;
    bit          in_fire        = 1'b0;
    bit          calm           = 1'b0;
    bit          long_hold_done = 1'b0;
    int unsigned send_gap       = 0;
    int unsigned out_hold       = 0;

    skyline_pareto_maxima dut (
        .i_clk,
        .i_rst_n,
        .i_in_valid,
        .o_in_stall,
        .i_in_data,
        .o_out_valid,
        .i_out_stall,
        .o_out_data,
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic t_in_item mk_point(input logic [COORD_BITS-1:0] a, b, c, d,
                                          input logic last);
        t_in_item pt;
        pt.coord_a    = a;
        pt.coord_b    = b;
        pt.coord_c    = c;
        pt.coord_d    = d;
        pt.last_point = last;
        return pt;
    endfunction

    // append one point to the driver queue
    task automatic queue_point(input t_in_item pt);
        pending_points.insert(pending_points.size(), pt);
    endtask

    // store one accepted point; on the closing point compute the skyline
    task automatic absorb_point(input t_in_item pt);
        logic [MAX_PTS-1:0] live;
        logic [MAX_PTS-1:0] sky;
        int                 d, m, i, k, last_idx;
        bit                 above, lower, higher;
        t_out_item          res;
        if (pt_count < MAX_PTS) begin
            pt_coord[pt_count][0] = pt.coord_a;
            pt_coord[pt_count][1] = pt.coord_b;
            pt_coord[pt_count][2] = pt.coord_c;
            pt_coord[pt_count][3] = pt.coord_d;
            pt_count++;
        end else begin
            pt_dropped = 1'b1;
        end
        if (!pt.last_point) return;

        // dimension count clamped to 1..AXES
        d = (dims_cfg == 0) ? 1 : (dims_cfg > AXES) ? AXES : int'(dims_cfg);
        live = '0;
        sky  = '0;
        for (i = 0; i < pt_count; i++) live[i] = 1'b1;
        while (live != '0) begin
            // lexicographic maximum, lowest index wins ties
            m = 0;
            while (!live[m]) m++;
            for (i = m + 1; i < MAX_PTS; i++) begin
                if (!live[i]) continue;
                above = 1'b0;
                for (k = 0; k < d; k++) begin
                    if (pt_coord[i][k] != pt_coord[m][k]) begin
                        above = pt_coord[i][k] > pt_coord[m][k];
                        break;
                    end
                end
                if (above) m = i;
            end
            live[m] = 1'b0;
            sky[m]  = 1'b1;
            // remove points the new maximum dominates
            for (i = 0; i < MAX_PTS; i++) begin
                if (!live[i]) continue;
                lower  = 1'b0;
                higher = 1'b0;
                for (k = 0; k < d; k++) begin
                    if (pt_coord[i][k] > pt_coord[m][k]) higher = 1'b1;
                    if (pt_coord[i][k] < pt_coord[m][k]) lower = 1'b1;
                end
                if (lower && !higher) live[i] = 1'b0;
            end
        end

        // indices in ascending order, final one marked
        last_idx = 0;
        for (i = 0; i < MAX_PTS; i++) if (sky[i]) last_idx = i;
        for (i = 0; i < MAX_PTS; i++) begin
            if (!sky[i]) continue;
            res.point_index = OUT_IDX_W'(i);
            res.last_result = (i == last_idx);
            res.overflow    = pt_dropped;
            sky_expect.insert(sky_expect.size(), res);
        end
        pt_count   = 0;
        pt_dropped = 1'b0;
    endtask

    // input transaction accepted: predict, retire from the pending queue
    always @(posedge i_clk) begin
        in_fire = i_rst_n && i_in_valid && !o_in_stall;
        if (in_fire) begin
            absorb_point(i_in_data);
            void'(pending_points.pop_front());
        end
    end

    // output transaction accepted: check against oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (sky_expect.size() == 0) begin
                $display("%0t unexpected result: index %0d last %0b overflow %0b", $time,
                         o_out_data.point_index, o_out_data.last_result,
                         o_out_data.overflow);
                mismatches++;
            end else begin
                want = sky_expect.pop_front();
                if (o_out_data.point_index !== want.point_index ||
                    o_out_data.last_result !== want.last_result ||
                    o_out_data.overflow !== want.overflow) begin
                    $display("%0t result mismatch: expected index %0d last %0b overflow %0b,",
                             $time, want.point_index, want.last_result, want.overflow);
                    $display("%0t   actual index %0d last %0b overflow %0b", $time,
                             o_out_data.point_index, o_out_data.last_result,
                             o_out_data.overflow);
                    mismatches++;
                end
            end
        end
    end

    // point driver
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && !in_fire)) begin
            if (in_fire) send_gap = pick_gap();
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_points.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_points[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver stall
    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            i_out_stall <= 1'b1;
            out_hold--;
        end else if (!long_hold_done && o_out_valid && pending_points.size() > 16) begin
            // hold off long enough for the block to back up into its input
            i_out_stall    <= 1'b1;
            out_hold       = LONG_HOLD;
            long_hold_done = 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            out_hold    = pick_gap();
        end
    end

    // register write, setup then access cycle
    task automatic write_dims(input logic [DIMS_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_DIMS_IN_USE, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        dims_cfg = value;
    endtask

    // queue one point set, the final point marked
    task automatic queue_set(input int unsigned n, input t_set_kind kind);
        logic [4*COORD_BITS-1:0] raw;
        int unsigned             j, k;
        for (j = 0; j < n; j++) begin
            raw = {$urandom, $urandom};
            case (kind)
                SET_TIES: begin
                    for (k = 0; k < AXES; k++)
                        raw[4*COORD_BITS-1-COORD_BITS*k -: COORD_BITS] =
                            COORD_BITS'($urandom_range(3));
                end
                SET_TRADEOFF: begin
                    // second coordinate falls as the first rises
                    raw[3*COORD_BITS-1 -: COORD_BITS] = ~raw[4*COORD_BITS-1 -: COORD_BITS];
                end
                SET_EXTREME: begin
                    for (k = 0; k < AXES; k++) begin
                        case ($urandom_range(2))
                            0: raw[4*COORD_BITS-1-COORD_BITS*k -: COORD_BITS] = '0;
                            1: raw[4*COORD_BITS-1-COORD_BITS*k -: COORD_BITS] = '1;
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
            queue_point({raw, (j == n - 1) ? 1'b1 : 1'b0});
        end
        queued += n;
    endtask

    // wait for all points taken and all results back, then let the block settle
    task automatic drain();
        while (pending_points.size() != 0 || sky_expect.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // stimulus
    initial begin
        int unsigned phase, phase_start, r, n;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_dims(3'd4);

        // lone point at full scale
        queue_point(mk_point('1, '1, '1, '1, 1'b1));
        // floor, ceiling on one axis and on three, a duplicate and a midpoint
        queue_point(mk_point('1, '0, '0, '0, 1'b0));
        queue_point(mk_point('0, '1, '1, '1, 1'b0));
        queue_point(mk_point('0, '0, '0, '0, 1'b0));
        queue_point(mk_point('1, '0, '0, '0, 1'b0));
        queue_point(mk_point(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1));
        // identical points all survive
        queue_point(mk_point(16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 1'b0));
        queue_point(mk_point(16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 1'b0));
        queue_point(mk_point(16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 1'b1));
        // alternating bit patterns
        queue_point(mk_point(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 1'b0));
        queue_point(mk_point(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 1'b1));
        // ties on leading axes decided further down
        queue_point(mk_point(16'd7, 16'd7, 16'd7, 16'd1, 1'b0));
        queue_point(mk_point(16'd7, 16'd7, 16'd7, 16'd2, 1'b0));
        queue_point(mk_point(16'd7, 16'd7, 16'd6, 16'd9, 1'b1));
        queued = pending_points.size();
        drain();

        // random phases, one dimension setting each
        phase = 0;
        while (queued < N_ITEMS) begin
            write_dims(DIMS_SWEEP[3*(phase%7) +: 3]);
            calm        = (phase % 3 == 2);
            phase_start = queued;
            while (queued - phase_start < 30 && queued < N_ITEMS) begin
                r = $urandom_range(99);
                if (r < 75) n = $urandom_range(6, 1);
                else if (r < 95) n = $urandom_range(20, 7);
                else n = $urandom_range(40, 21);
                queue_set(n, t_set_kind'($urandom_range(3)));
            end
            // store full: points past capacity, the closing one dropped too
            if (phase == 1) queue_set(MAX_PTS + $urandom_range(6, 1), SET_SPREAD);
            // full store where every point is on the skyline
            if (phase == 3) queue_set(MAX_PTS, SET_TRADEOFF);
            drain();
            phase++;
        end

        if (mismatches == 0) begin
            $display("skyline_pareto_maxima verification clean");
        end else begin
            $display("skyline_pareto_maxima verification failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("skyline_pareto_maxima verification failed");
        $finish;
    end

endmodule
